// ----- sv/simon3264_pkg.sv -----
// types, constants and word functions shared by the simon 32/64 cipher unit
// no dependencies

package simon3264_pkg;

   localparam int WORD_W    = 16;
   localparam int KEY_WORDS = 4;
   localparam int CSR_IDX_W = 3;
   localparam int ROUNDS_W  = 6;

   localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 6'd32;

   // z0 sequence, bit 0 first
   localparam logic [61:0] Z0_SEQ = 62'h19C3522FB386A45F;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_0    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_1    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_2    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_3    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUNDS_IN_USE = 3'd4;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef logic [WORD_W-1:0] word_type;

   // one word in flight: x is the word the round function acts on
   typedef struct packed {
      logic     op;
      logic     last;
      word_type x;
      word_type y;
   } stage_type;

   function automatic word_type rotl(input word_type v, input int unsigned amount);
      return (v << amount) | (v >> (WORD_W - amount));
   endfunction

   function automatic word_type rotr(input word_type v, input int unsigned amount);
      return (v >> amount) | (v << (WORD_W - amount));
   endfunction

   function automatic logic z0_bit(input logic [5:0] pos);
      return Z0_SEQ[pos];
   endfunction

   // new x of one round
   function automatic word_type round_x(input word_type x, input word_type y,
                                        input word_type k);
      return y ^ (rotl(x, 1) & rotl(x, 8)) ^ rotl(x, 2) ^ k;
   endfunction

   // next round key from k[i-4], k[i-3], k[i-1]
   function automatic word_type next_key(input word_type k4, input word_type k3,
                                         input word_type k1, input logic zb);
      word_type t;
      t = rotr(k1, 3) ^ k3;
      t = t ^ rotr(t, 1);
      return ~k4 ^ t ^ {{(WORD_W-1){1'b0}}, zb} ^ word_type'(3);
   endfunction

endpackage

// ----- sv/simon3264_key_sched.sv -----
// round key sequencer: loads the key words and expands them one key per cycle
// depends on simon3264_pkg

module simon3264_key_sched
   import simon3264_pkg::*;
#(
   parameter int FULL_ROUNDS = 32
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     key_write,
   input  word_type key_word [KEY_WORDS],
   output word_type round_key [FULL_ROUNDS],
   output logic     keys_ready
);

   localparam int IDX_W = $clog2(FULL_ROUNDS);

   typedef enum logic [2:0] {
      SCHED_LOAD   = 3'b001,
      SCHED_EXPAND = 3'b010,
      SCHED_READY  = 3'b100
   } sched_state_type;

   sched_state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   word_type         win_ff [KEY_WORDS];
   word_type         round_key_ff [FULL_ROUNDS];
   word_type         new_key;
   logic [IDX_W-1:0] z_pos;

   assign z_pos   = idx_ff - IDX_W'(KEY_WORDS);
   assign new_key = next_key(win_ff[0], win_ff[1], win_ff[3], z0_bit(6'(z_pos)));

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         SCHED_LOAD: begin
            state_in = SCHED_EXPAND;
            idx_in   = IDX_W'(KEY_WORDS);
         end
         SCHED_EXPAND: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(FULL_ROUNDS - 1)) begin
               state_in = SCHED_READY;
            end
         end
         SCHED_READY: begin
            state_in = SCHED_READY;
         end
         default: begin
            state_in = SCHED_LOAD;
         end
      endcase
      if (key_write) begin
         state_in = SCHED_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCHED_LOAD;
         idx_ff   <= IDX_W'(KEY_WORDS);
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // sliding window holds k[i-4] .. k[i-1]
   always_ff @(posedge clock) begin
      if (state_ff == SCHED_LOAD) begin
         for (int j = 0; j < KEY_WORDS; j++) begin
            win_ff[j] <= key_word[KEY_WORDS-1-j];
         end
      end else if (state_ff == SCHED_EXPAND) begin
         for (int j = 0; j < KEY_WORDS - 1; j++) begin
            win_ff[j] <= win_ff[j+1];
         end
         win_ff[KEY_WORDS-1] <= new_key;
      end
   end

   for (genvar j = 0; j < FULL_ROUNDS; j++) begin : g_key
      if (j < KEY_WORDS) begin : g_init
         always_ff @(posedge clock) begin
            if (state_ff == SCHED_LOAD) begin
               round_key_ff[j] <= key_word[KEY_WORDS-1-j];
            end
         end
      end else begin : g_gen
         always_ff @(posedge clock) begin
            if (state_ff == SCHED_EXPAND && idx_ff == IDX_W'(j)) begin
               round_key_ff[j] <= new_key;
            end
         end
      end
      assign round_key[j] = round_key_ff[j];
   end

   assign keys_ready = (state_ff == SCHED_READY);

   a_write_restarts: assert property (@(posedge clock) disable iff (reset)
      key_write |=> state_ff == SCHED_LOAD)
      else $error("key write did not restart the schedule");

   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(keys_ready) |-> $past(idx_ff) == IDX_W'(FULL_ROUNDS - 1))
      else $error("schedule ready before the last key was made");

   a_expand_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == SCHED_EXPAND |-> idx_ff >= IDX_W'(KEY_WORDS))
      else $error("expansion index below the initial keys");

endmodule

// ----- sv/simon3264_round.sv -----
// one pipeline stage: a single simon round, skipped when the stage is not in use
// depends on simon3264_pkg

module simon3264_round
   import simon3264_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      valid_i,
   input  stage_type stage_i,
   input  word_type  enc_key,
   input  word_type  dec_key,
   input  logic      enc_active,
   input  logic      dec_active,
   output logic      valid_o,
   output stage_type stage_o
);

   logic      valid_ff;
   stage_type stage_ff, stage_in;
   word_type  key;
   logic      active;

   always_comb begin
      key      = (stage_i.op == OP_DECRYPT) ? dec_key : enc_key;
      active   = (stage_i.op == OP_DECRYPT) ? dec_active : enc_active;
      stage_in = stage_i;
      if (active) begin
         stage_in.x = round_x(stage_i.x, stage_i.y, key);
         stage_in.y = stage_i.x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign valid_o = valid_ff;
   assign stage_o = stage_ff;

endmodule

// ----- sv/simon3264_block_cipher_unit.sv -----
// Simon 32/64 block cipher unit, codebook use, one round per pipeline stage.
// Channels: req_ takes one block word per accepted handshake (tuser = op,
// 0 encrypt / 1 decrypt; tlast = last block mark), rsp_ returns the
// transformed block with the same tlast. csr_ writes key words 0..3
// (index 0..3) and the round count (index 4); other indexes are ignored.
// Throughput: one word per cycle, set by the FULL_ROUNDS-stage round pipeline,
// while rsp_ is not stalled and the key schedule is ready.
// Key schedule: after reset and after any key word write, the sequencer
// loads the key words and then expands the round keys, making
// one key per cycle; req_tready is low until it is done.
// Rounds above FULL_ROUNDS count as FULL_ROUNDS; zero rounds pass the block.
// Reset clears the pipeline, the key words and sets the round count to 32.
// A stalled rsp_ holds the whole pipeline and req_tready drops in that cycle.
// depends on simon3264_pkg, simon3264_key_sched, simon3264_round

module simon_32_64_block_cipher_unit
   import simon3264_pkg::*;
#(
   parameter int FULL_ROUNDS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   // word_first [15:0], word_second [31:16]
   input  logic [31:0]          req_tdata,
   // op [0]
   input  logic                 req_tuser,
   input  logic                 req_tlast,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // out_first [15:0], out_second [31:16]
   output logic [31:0]          rsp_tdata,
   output logic                 rsp_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WORD_W-1:0]    csr_data
);

   localparam int CNT_W = $clog2(FULL_ROUNDS + 1);
   localparam int CMP_W = (CNT_W > ROUNDS_W) ? CNT_W : ROUNDS_W;

   word_type            key_word_ff [KEY_WORDS];
   logic [ROUNDS_W-1:0] rounds_ff;
   logic                csr_fire;
   logic                key_write;
   word_type            round_key [FULL_ROUNDS];
   logic                keys_ready;
   logic [CMP_W-1:0]    rounds_ext;
   logic [CMP_W-1:0]    rounds_eff;
   logic                advance;
   logic                req_fire;
   stage_type           entry;
   logic                valid_q [FULL_ROUNDS];
   stage_type           stage_q [FULL_ROUNDS];
   stage_type           tail;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign key_write = csr_fire && (csr_index inside {CSR_KEY_WORD_0, CSR_KEY_WORD_1,
                                                     CSR_KEY_WORD_2, CSR_KEY_WORD_3});

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < KEY_WORDS; j++) begin
            key_word_ff[j] <= '0;
         end
         rounds_ff <= ROUNDS_RESET;
      end else if (csr_fire) begin
         case (csr_index)
            CSR_KEY_WORD_0:    key_word_ff[0] <= csr_data;
            CSR_KEY_WORD_1:    key_word_ff[1] <= csr_data;
            CSR_KEY_WORD_2:    key_word_ff[2] <= csr_data;
            CSR_KEY_WORD_3:    key_word_ff[3] <= csr_data;
            CSR_ROUNDS_IN_USE: rounds_ff <= csr_data[ROUNDS_W-1:0];
            default: ;
         endcase
      end
   end

   simon3264_key_sched #(
      .FULL_ROUNDS(FULL_ROUNDS)
   ) u_key_sched (
      .clock      (clock),
      .reset      (reset),
      .key_write  (key_write),
      .key_word   (key_word_ff),
      .round_key  (round_key),
      .keys_ready (keys_ready)
   );

   assign rounds_ext = CMP_W'(rounds_ff);
   assign rounds_eff = (rounds_ext > CMP_W'(FULL_ROUNDS)) ? CMP_W'(FULL_ROUNDS) : rounds_ext;

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance && keys_ready;
   assign req_fire   = req_tvalid && req_tready;

   // decrypt runs with the words swapped
   always_comb begin
      entry.op   = req_tuser;
      entry.last = req_tlast;
      if (req_tuser == OP_DECRYPT) begin
         entry.x = req_tdata[31:16];
         entry.y = req_tdata[15:0];
      end else begin
         entry.x = req_tdata[15:0];
         entry.y = req_tdata[31:16];
      end
   end

   // encrypt uses the first stages, decrypt the last ones with keys counting down
   for (genvar s = 0; s < FULL_ROUNDS; s++) begin : g_stage
      logic      stg_valid;
      stage_type stg_in;
      if (s == 0) begin : g_head
         assign stg_valid = req_fire;
         assign stg_in    = entry;
      end else begin : g_body
         assign stg_valid = valid_q[s-1];
         assign stg_in    = stage_q[s-1];
      end
      simon3264_round u_round (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .valid_i    (stg_valid),
         .stage_i    (stg_in),
         .enc_key    (round_key[s]),
         .dec_key    (round_key[FULL_ROUNDS-1-s]),
         .enc_active (CMP_W'(s) < rounds_eff),
         .dec_active (rounds_eff > CMP_W'(FULL_ROUNDS - 1 - s)),
         .valid_o    (valid_q[s]),
         .stage_o    (stage_q[s])
      );
   end

   assign tail       = stage_q[FULL_ROUNDS-1];
   assign rsp_tvalid = valid_q[FULL_ROUNDS-1];
   assign rsp_tlast  = tail.last;
   assign rsp_tdata  = (tail.op == OP_DECRYPT) ? {tail.x, tail.y} : {tail.y, tail.x};

   a_accept_needs_keys: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> keys_ready)
      else $error("word accepted before the key schedule was ready");

   a_key_write_blocks: assert property (@(posedge clock) disable iff (reset)
      (csr_fire && (csr_index == CSR_KEY_WORD_0 || csr_index == CSR_KEY_WORD_1 ||
                    csr_index == CSR_KEY_WORD_2 || csr_index == CSR_KEY_WORD_3))
      |=> !req_tready)
      else $error("input open right after a key write");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while the pipeline is stalled");

endmodule

// ----- verif/simon_32_64_block_cipher_unit_tb.sv -----
// self-checking testbench for the simon 32/64 block cipher unit: random-gap stream driver,
// randomly stalling response monitor and a cycle-free predictor of the cipher and key schedule
// depends on simon3264_pkg and simon_32_64_block_cipher_unit
`timescale 1ns / 100ps

module simon_32_64_block_cipher_unit_tb;
   import simon3264_pkg::*;

   localparam int ROUND_STAGES   = 32;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int RANDOM_BLOCKS  = 1900;

   typedef struct {
      logic     op;
      word_type first;
      word_type second;
      logic     last;
   } cipher_block_type;

   typedef struct {
      word_type first;
      word_type second;
      logic     last;
   } cipher_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic [31:0]          req_tdata = '0;
   logic                 req_tuser = 1'b0;
   logic                 req_tlast = 1'b0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [31:0]          rsp_tdata;
   logic                 rsp_tlast;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [WORD_W-1:0]    csr_data = '0;

   simon_32_64_block_cipher_unit #(
      .FULL_ROUNDS(ROUND_STAGES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   word_type            shadow_key [KEY_WORDS];
   word_type            round_key_table [ROUND_STAGES];
   logic [ROUNDS_W-1:0] round_count = ROUNDS_RESET;

   cipher_block_type  blocks_to_send [$];
   cipher_result_type expected_blocks [$];
   cipher_block_type  offered_block;
   logic              offered = 1'b0;
   int                send_gap = 0;
   int                stall_left = 0;
   logic              no_idle = 1'b0;
   int                mismatch_count = 0;
   int                quiet_cycles = 0;

   function automatic word_type rot_left(input word_type v, input int s);
      return word_type'({v, v} >> (WORD_W - s));
   endfunction

   function automatic word_type rot_right(input word_type v, input int s);
      return word_type'({v, v} >> s);
   endfunction

   function automatic word_type feistel_step(input word_type x, input word_type y,
                                             input word_type k);
      return y ^ (rot_left(x, 1) & rot_left(x, 8)) ^ rot_left(x, 2) ^ k;
   endfunction

   function automatic void expand_round_keys();
      word_type t;
      for (int i = 0; i < KEY_WORDS; i++)
         round_key_table[i] = shadow_key[KEY_WORDS-1-i];
      for (int i = KEY_WORDS; i < ROUND_STAGES; i++) begin
         t = rot_right(round_key_table[i-1], 3) ^ round_key_table[i-3];
         t = t ^ rot_right(t, 1);
         round_key_table[i] = ~round_key_table[i-KEY_WORDS] ^ t
                              ^ word_type'(Z0_SEQ[(i-KEY_WORDS) % 62]) ^ word_type'(3);
      end
   endfunction

   function automatic cipher_result_type cipher_model(input cipher_block_type b);
      cipher_result_type res;
      word_type          x;
      word_type          y;
      word_type          prev;
      int                n;
      n = (round_count > ROUND_STAGES) ? ROUND_STAGES : int'(round_count);
      if (b.op == OP_ENCRYPT) begin
         x = b.first;
         y = b.second;
         for (int r = 0; r < n; r++) begin
            prev = x;
            x = feistel_step(x, y, round_key_table[r]);
            y = prev;
         end
         res.first  = x;
         res.second = y;
      end else begin
         x = b.second;
         y = b.first;
         for (int r = n - 1; r >= 0; r--) begin
            prev = x;
            x = feistel_step(x, y, round_key_table[r]);
            y = prev;
         end
         res.first  = y;
         res.second = x;
      end
      res.last = b.last;
      return res;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic word_type random_word();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return word_type'($urandom);
   endfunction

   function automatic void queue_block(input logic op, input word_type first,
                                       input word_type second, input logic last);
      cipher_block_type b;
      b.op     = op;
      b.first  = first;
      b.second = second;
      b.last   = last;
      blocks_to_send.push_back(b);
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input word_type data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_KEY_WORD_0, CSR_KEY_WORD_1, CSR_KEY_WORD_2, CSR_KEY_WORD_3: begin
            shadow_key[idx[1:0]] = data;
         end
         CSR_ROUNDS_IN_USE: begin
            round_count = data[ROUNDS_W-1:0];
         end
         default: begin
         end
      endcase
      expand_round_keys();
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (blocks_to_send.size() != 0 || offered || expected_blocks.size() != 0);
      repeat (ROUND_STAGES + 4) @(negedge clock);
   endtask

   task automatic load_key(input word_type k0, input word_type k1,
                           input word_type k2, input word_type k3);
      write_csr(CSR_KEY_WORD_0, k0);
      write_csr(CSR_KEY_WORD_1, k1);
      write_csr(CSR_KEY_WORD_2, k2);
      write_csr(CSR_KEY_WORD_3, k3);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         offered = 1'b0;
         send_gap = 0;
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_blocks.push_back(cipher_model(offered_block));
            offered = 1'b0;
         end
         if (!offered) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (blocks_to_send.size() != 0) begin
               offered_block = blocks_to_send.pop_front();
               req_tdata <= {offered_block.second, offered_block.first};
               req_tuser <= offered_block.op;
               req_tlast <= offered_block.last;
               offered = 1'b1;
               send_gap = idle_length();
            end
         end
         req_tvalid <= offered;
      end
   end

   // response monitor
   always @(posedge clock) begin
      cipher_result_type want;
      if (reset) begin
         stall_left = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_blocks.size() == 0) begin
               $display("%0t: unexpected word tdata %h tlast %b", $time, rsp_tdata, rsp_tlast);
               mismatch_count++;
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_tdata[15:0] !== want.first) begin
                  $display("%0t: out_first expected %h actual %h",
                           $time, want.first, rsp_tdata[15:0]);
                  mismatch_count++;
               end
               if (rsp_tdata[31:16] !== want.second) begin
                  $display("%0t: out_second expected %h actual %h",
                           $time, want.second, rsp_tdata[31:16]);
                  mismatch_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $display("%0t: last_out expected %b actual %b", $time, want.last, rsp_tlast);
                  mismatch_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = idle_length();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int       random_total;
      int       phase_len;
      int       pick;
      word_type rounds_data;
      random_total = 0;
      foreach (shadow_key[i]) shadow_key[i] = '0;
      expand_round_keys();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset keys, schedule built after reset
      queue_block(OP_ENCRYPT, 16'h0000, 16'h0000, 1'b0);
      queue_block(OP_DECRYPT, 16'hFFFF, 16'hFFFF, 1'b1);
      queue_block(OP_ENCRYPT, 16'h0000, 16'hFFFF, 1'b1);
      queue_block(OP_DECRYPT, 16'hFFFF, 16'h0000, 1'b0);
      wait_drained();

      // published test vector key, full rounds
      load_key(16'h1918, 16'h1110, 16'h0908, 16'h0100);
      write_csr(CSR_ROUNDS_IN_USE, 16'd32);
      queue_block(OP_ENCRYPT, 16'h6565, 16'h6877, 1'b0);
      queue_block(OP_DECRYPT, 16'hC69B, 16'hE9BB, 1'b1);
      queue_block(OP_ENCRYPT, 16'hFFFF, 16'hFFFF, 1'b0);
      queue_block(OP_DECRYPT, 16'h0000, 16'h0000, 1'b1);
      wait_drained();

      // zero rounds pass the block through
      write_csr(CSR_ROUNDS_IN_USE, 16'd0);
      queue_block(OP_ENCRYPT, 16'h1234, 16'hABCD, 1'b1);
      queue_block(OP_DECRYPT, 16'hFFFF, 16'h0000, 1'b0);
      wait_drained();

      // counts above the pipeline depth saturate
      write_csr(CSR_ROUNDS_IN_USE, 16'd63);
      queue_block(OP_ENCRYPT, 16'h6565, 16'h6877, 1'b0);
      queue_block(OP_DECRYPT, 16'hC69B, 16'hE9BB, 1'b1);
      wait_drained();
      write_csr(CSR_ROUNDS_IN_USE, 16'd33);
      queue_block(OP_ENCRYPT, 16'hA5A5, 16'h5A5A, 1'b1);
      wait_drained();

      // single round, then writes to unused indexes
      write_csr(CSR_ROUNDS_IN_USE, 16'd1);
      queue_block(OP_ENCRYPT, 16'h8001, 16'h7FFE, 1'b0);
      queue_block(OP_DECRYPT, 16'h7FFE, 16'h8001, 1'b1);
      wait_drained();
      write_csr(CSR_ROUNDS_IN_USE + 3'd1, 16'hFFFF);
      write_csr(CSR_ROUNDS_IN_USE + 3'd3, 16'hFFFF);
      queue_block(OP_ENCRYPT, 16'h0F0F, 16'hF0F0, 1'b1);
      queue_block(OP_DECRYPT, 16'h0F0F, 16'hF0F0, 1'b0);
      wait_drained();

      // all-ones key, 31 rounds
      load_key(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      write_csr(CSR_ROUNDS_IN_USE, 16'd31);
      queue_block(OP_ENCRYPT, 16'hFFFF, 16'h0000, 1'b1);
      queue_block(OP_DECRYPT, 16'h0000, 16'hFFFF, 1'b0);
      queue_block(OP_ENCRYPT, 16'h0000, 16'h0000, 1'b1);
      wait_drained();

      while (random_total < RANDOM_BLOCKS) begin
         no_idle = ($urandom_range(0, 4) == 0);
         for (int i = 0; i < KEY_WORDS; i++)
            if ($urandom_range(0, 1))
               write_csr(CSR_IDX_W'(CSR_KEY_WORD_0 + i), random_word());
         pick = $urandom_range(0, 9);
         rounds_data = word_type'($urandom);
         case (pick)
            0: rounds_data[ROUNDS_W-1:0] = '0;
            1: rounds_data[ROUNDS_W-1:0] = 6'd32;
            2: rounds_data[ROUNDS_W-1:0] = 6'($urandom_range(33, 63));
            3: rounds_data[ROUNDS_W-1:0] = 6'd1;
            default: rounds_data[ROUNDS_W-1:0] = 6'($urandom_range(1, 32));
         endcase
         write_csr(CSR_ROUNDS_IN_USE, rounds_data);
         if ($urandom_range(0, 5) == 0)
            write_csr(CSR_ROUNDS_IN_USE + 3'($urandom_range(1, 3)), word_type'($urandom));
         phase_len = $urandom_range(10, 120);
         for (int i = 0; i < phase_len; i++)
            queue_block($urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT, random_word(),
                        random_word(), $urandom_range(0, 7) == 0);
         random_total += phase_len;
         wait_drained();
      end

      no_idle = 1'b0;
      repeat (ROUND_STAGES + 8) @(negedge clock);
      if (mismatch_count == 0 && expected_blocks.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/simon3264_pkg.sv
sv/simon3264_key_sched.sv
sv/simon3264_round.sv
sv/simon3264_block_cipher_unit.sv
verif/simon_32_64_block_cipher_unit_tb.sv
